// File: hdl/cmce_pkg.sv
package cmce_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [15:0] BITPOS_INIT = 16'h0001;
    localparam logic [7:0]  LRC_MASK = 8'hFF;

    localparam int unsigned METHOD_W = 3;

    localparam logic [METHOD_W-1:0] METHOD_CRC16  = 3'd0;
    localparam logic [METHOD_W-1:0] METHOD_PARITY = 3'd1;
    localparam logic [METHOD_W-1:0] METHOD_INET   = 3'd2;
    localparam logic [METHOD_W-1:0] METHOD_LRC    = 3'd3;
    localparam logic [METHOD_W-1:0] METHOD_BITSIG = 3'd4;

    // One queued message item: a byte, an end marker, or both.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_item;

endpackage

// File: hdl/cmce_front.sv
module cmce_front (
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [7:0]         s_axis_tdata,
    input  logic               s_axis_tuser,
    input  logic               s_axis_tlast,
    input  logic               i_queue_full,
    output logic               o_push,
    output cmce_pkg::t_item    o_item
);

    logic w_accept;

    assign s_axis_tready = !i_queue_full;
    assign w_accept      = s_axis_tvalid && !i_queue_full;

    // A beat with neither a byte nor an end marker changes nothing, so it is
    // taken here and never reaches the queue.
    assign o_push = w_accept && (s_axis_tuser || s_axis_tlast);

    assign o_item.data_byte      = s_axis_tdata;
    assign o_item.byte_present   = s_axis_tuser;
    assign o_item.end_of_message = s_axis_tlast;

endmodule

// File: hdl/cmce_queue.sv
module cmce_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cmce_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_empty,
    output cmce_pkg::t_item o_item
);

    localparam int unsigned ADDR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned COUNT_W = $clog2(DEPTH + 1);
    localparam logic [ADDR_W-1:0]  LAST_ADDR = ADDR_W'(DEPTH - 1);
    localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(DEPTH);

    cmce_pkg::t_item    r_mem [DEPTH];
    logic [ADDR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [ADDR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [COUNT_W-1:0] r_count, n_count;
    logic               w_push, w_pop;

    assign o_full  = (r_count == FULL_COUNT);
    assign o_empty = (r_count == '0);
    assign o_item  = r_mem[r_rd_ptr];

    assign w_push = i_push && !o_full;
    assign w_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_ADDR) ? '0 : r_wr_ptr + ADDR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_ADDR) ? '0 : r_rd_ptr + ADDR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + COUNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - COUNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

endmodule

// File: hdl/cmce_back.sv
module cmce_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_wr_en,
    input  logic [cmce_pkg::METHOD_W-1:0]    i_cfg_wr_data,
    input  logic                             i_queue_empty,
    input  cmce_pkg::t_item                  i_item,
    output logic                             o_pop,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [15:0]                      m_axis_tdata
);

    logic [cmce_pkg::METHOD_W-1:0] r_method;

    logic [15:0] r_crc, n_crc;
    logic        r_parity, n_parity;
    logic [15:0] r_csum, n_csum;
    logic [7:0]  r_held, n_held;
    logic        r_odd, n_odd;
    logic [7:0]  r_lrc, n_lrc;
    logic [15:0] r_sig, n_sig;
    logic [15:0] r_bitpos, n_bitpos;

    logic        r_out_valid;
    logic [15:0] r_out_data;

    logic [7:0]  w_byte;
    logic        w_present;
    logic [15:0] w_csum_addend;
    logic [16:0] w_csum_raw;
    logic [15:0] w_csum_sum;
    logic [15:0] w_result;

    assign w_byte    = i_item.data_byte;
    assign w_present = i_item.byte_present;

    // An end beat may only leave the queue when the output register frees up.
    assign o_pop = !i_queue_empty
        && (!i_item.end_of_message || !r_out_valid || m_axis_tready);

    // One ones' complement adder serves both a completed byte pair and the
    // closing add of an odd trailing byte.
    always_comb begin
        if (w_present) begin
            w_csum_addend = r_odd ? {w_byte, r_held} : {8'h00, w_byte};
        end else begin
            w_csum_addend = r_odd ? {8'h00, r_held} : 16'h0000;
        end
        w_csum_raw = {1'b0, r_csum} + {1'b0, w_csum_addend};
        w_csum_sum = w_csum_raw[15:0] + {15'd0, w_csum_raw[16]};
    end

    always_comb begin
        logic [15:0] v_crc;
        v_crc    = r_crc ^ {8'h00, w_byte};
        n_sig    = r_sig;
        n_crc    = r_crc;
        n_parity = r_parity;
        n_csum   = r_csum;
        n_held   = r_held;
        n_odd    = r_odd;
        n_lrc    = r_lrc;
        n_bitpos = r_bitpos;
        if (w_present) begin
            for (int k = 0; k < 8; k++) begin
                v_crc = v_crc[0] ? ((v_crc >> 1) ^ cmce_pkg::CRC_POLY) : (v_crc >> 1);
            end
            for (int k = 0; k < 8; k++) begin
                if (w_byte[k]) begin
                    n_sig = n_sig ^ (r_bitpos + 16'(k));
                end
            end
            n_crc    = v_crc;
            n_parity = r_parity ^ (^w_byte);
            n_bitpos = r_bitpos + 16'd8;
            n_lrc    = r_lrc ^ w_byte;
            if (r_odd) begin
                n_csum = w_csum_sum;
                n_held = 8'h00;
                n_odd  = 1'b0;
            end else begin
                n_held = w_byte;
                n_odd  = 1'b1;
            end
        end
    end

    always_comb begin
        unique case (r_method)
            cmce_pkg::METHOD_CRC16:  w_result = n_crc;
            cmce_pkg::METHOD_PARITY: w_result = {15'd0, n_parity};
            cmce_pkg::METHOD_INET:   w_result = ~w_csum_sum;
            cmce_pkg::METHOD_LRC:    w_result = {n_lrc, n_lrc ^ cmce_pkg::LRC_MASK};
            cmce_pkg::METHOD_BITSIG: w_result = n_sig;
            default:                 w_result = 16'h0000;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_method    <= cmce_pkg::METHOD_CRC16;
            r_crc       <= cmce_pkg::CRC_INIT;
            r_parity    <= 1'b0;
            r_csum      <= 16'h0000;
            r_held      <= 8'h00;
            r_odd       <= 1'b0;
            r_lrc       <= 8'h00;
            r_sig       <= 16'h0000;
            r_bitpos    <= cmce_pkg::BITPOS_INIT;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_method <= i_cfg_wr_data;
            end
            if (o_pop) begin
                if (i_item.end_of_message) begin
                    r_crc    <= cmce_pkg::CRC_INIT;
                    r_parity <= 1'b0;
                    r_csum   <= 16'h0000;
                    r_held   <= 8'h00;
                    r_odd    <= 1'b0;
                    r_lrc    <= 8'h00;
                    r_sig    <= 16'h0000;
                    r_bitpos <= cmce_pkg::BITPOS_INIT;
                end else begin
                    r_crc    <= n_crc;
                    r_parity <= n_parity;
                    r_csum   <= n_csum;
                    r_held   <= n_held;
                    r_odd    <= n_odd;
                    r_lrc    <= n_lrc;
                    r_sig    <= n_sig;
                    r_bitpos <= n_bitpos;
                end
            end
            if (o_pop && i_item.end_of_message) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && i_item.end_of_message) begin
            r_out_data <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

// File: hdl/multi_method_check_code_engine_core.sv
// Path: an accepted end beat is written into the queue; once the beats ahead
// of it have left, it is popped and its result is registered for output.
// Throughput: one input beat per cycle while the queue is not full; the back
// end computes a byte's eight CRC rounds and bit signature combinationally.
// Reset: synchronous, active low; clears the queue, the output valid flag and
// the running checks, and selects the CRC-16 method.
module multi_method_check_code_engine_core #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [cmce_pkg::METHOD_W-1:0] i_cfg_wr_data,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,  // [7:0] data_byte
    input  logic                          s_axis_tuser,  // [0] byte_present
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [15:0]                   m_axis_tdata   // [15:0] check_code
);

    logic            w_push;
    logic            w_full;
    logic            w_pop;
    logic            w_empty;
    cmce_pkg::t_item w_front_item;
    cmce_pkg::t_item w_back_item;

    cmce_front u_front (
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .i_queue_full  (w_full),
        .o_push        (w_push),
        .o_item        (w_front_item)
    );

    cmce_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_item  (w_back_item)
    );

    cmce_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_queue_empty (w_empty),
        .i_item        (w_back_item),
        .o_pop         (w_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// File: tb/tb_multi_method_check_code_engine_core.sv
`timescale 1ns / 100ps

module tb_multi_method_check_code_engine_core;

    // Codes 5 to 7 select no check and must report zero.
    localparam logic [cmce_pkg::METHOD_W-1:0] METHOD_RSVD_5 = 3'd5;
    localparam logic [cmce_pkg::METHOD_W-1:0] METHOD_RSVD_6 = 3'd6;
    localparam logic [cmce_pkg::METHOD_W-1:0] METHOD_RSVD_7 = 3'd7;

    localparam int SETTLE_CYCLES = 12;
    localparam int STALL_CYCLES  = 300;
    localparam int IDLE_LIMIT    = 3000;
    localparam int PHASE_BYTES   = 88;

    typedef enum logic {ROW_BEAT, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind                     kind;
        logic [cmce_pkg::METHOD_W-1:0] method;
        logic [7:0]                    data_byte;
        logic                          byte_present;
        logic                          end_of_message;
        logic                          golden_valid;
        logic [15:0]                   golden;
    } t_dir_row;

    typedef struct {
        logic [15:0] crc;
        logic        parity;
        logic [15:0] csum;
        logic [7:0]  held_lo;
        logic        odd;
        logic [7:0]  lrc;
        logic [15:0] sig;
        logic [15:0] bitpos;
    } t_msg_sums;

    localparam int DIR_ROWS = 31;

    t_dir_row dir_tab [DIR_ROWS] = '{
        '{ROW_BEAT, cmce_pkg::METHOD_CRC16,  8'h00, 1'b0, 1'b1, 1'b1, 16'hFFFF},
        '{ROW_BEAT, cmce_pkg::METHOD_CRC16,  8'h00, 1'b1, 1'b0, 1'b0, 16'h0000},
        '{ROW_BEAT, cmce_pkg::METHOD_CRC16,  8'hA5, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{ROW_BEAT, cmce_pkg::METHOD_CRC16,  8'hFF, 1'b1, 1'b1, 1'b0, 16'h0000},
        '{ROW_CFG,  cmce_pkg::METHOD_PARITY, 8'h00, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{ROW_BEAT, cmce_pkg::METHOD_PARITY, 8'h01, 1'b1, 1'b1, 1'b1, 16'h0001},
        '{ROW_BEAT, cmce_pkg::METHOD_PARITY, 8'hFF, 1'b1, 1'b1, 1'b1, 16'h0000},
        '{ROW_BEAT, cmce_pkg::METHOD_PARITY, 8'h00, 1'b0, 1'b1, 1'b1, 16'h0000},
        '{ROW_CFG,  cmce_pkg::METHOD_INET,   8'h00, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{ROW_BEAT, cmce_pkg::METHOD_INET,   8'h00, 1'b0, 1'b1, 1'b1, 16'hFFFF},
        '{ROW_BEAT, cmce_pkg::METHOD_INET,   8'h34, 1'b1, 1'b0, 1'b0, 16'h0000},
        '{ROW_BEAT, cmce_pkg::METHOD_INET,   8'h12, 1'b1, 1'b1, 1'b1, 16'hEDCB},
        '{ROW_BEAT, cmce_pkg::METHOD_INET,   8'hFF, 1'b1, 1'b0, 1'b0, 16'h0000},
        '{ROW_BEAT, cmce_pkg::METHOD_INET,   8'hFF, 1'b1, 1'b0, 1'b0, 16'h0000},
        '{ROW_BEAT, cmce_pkg::METHOD_INET,   8'hFF, 1'b1, 1'b1, 1'b0, 16'h0000},
        '{ROW_CFG,  cmce_pkg::METHOD_LRC,    8'h00, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{ROW_BEAT, cmce_pkg::METHOD_LRC,    8'h00, 1'b0, 1'b1, 1'b1, 16'h00FF},
        '{ROW_BEAT, cmce_pkg::METHOD_LRC,    8'hA5, 1'b1, 1'b1, 1'b1, 16'hA55A},
        '{ROW_CFG,  cmce_pkg::METHOD_BITSIG, 8'h00, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{ROW_BEAT, cmce_pkg::METHOD_BITSIG, 8'h00, 1'b0, 1'b1, 1'b1, 16'h0000},
        '{ROW_BEAT, cmce_pkg::METHOD_BITSIG, 8'h80, 1'b1, 1'b1, 1'b1, 16'h0008},
        '{ROW_BEAT, cmce_pkg::METHOD_BITSIG, 8'h01, 1'b1, 1'b0, 1'b0, 16'h0000},
        '{ROW_BEAT, cmce_pkg::METHOD_BITSIG, 8'h01, 1'b1, 1'b1, 1'b0, 16'h0000},
        '{ROW_CFG,  METHOD_RSVD_5,           8'h00, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{ROW_BEAT, METHOD_RSVD_5,           8'hFF, 1'b1, 1'b1, 1'b1, 16'h0000},
        '{ROW_CFG,  METHOD_RSVD_7,           8'h00, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{ROW_BEAT, METHOD_RSVD_7,           8'h00, 1'b0, 1'b1, 1'b1, 16'h0000},
        '{ROW_CFG,  METHOD_RSVD_6,           8'h00, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{ROW_BEAT, METHOD_RSVD_6,           8'h55, 1'b1, 1'b1, 1'b1, 16'h0000},
        '{ROW_CFG,  cmce_pkg::METHOD_CRC16,  8'h00, 1'b0, 1'b0, 1'b0, 16'h0000},
        '{ROW_BEAT, cmce_pkg::METHOD_CRC16,  8'h00, 1'b1, 1'b1, 1'b0, 16'h0000}
    };

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_cfg_wr_en = 1'b0;
    logic [cmce_pkg::METHOD_W-1:0] i_cfg_wr_data = '0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [7:0]                    s_axis_tdata = 8'h00;
    logic                          s_axis_tuser = 1'b0;
    logic                          s_axis_tlast = 1'b0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [15:0]                   m_axis_tdata;

    // Travels with each beat so that directed rows can carry a typed-in value.
    logic        golden_valid = 1'b0;
    logic [15:0] golden_value = 16'h0000;

    logic [15:0]                   expected_check_q [$];
    t_msg_sums                     sums;
    logic [cmce_pkg::METHOD_W-1:0] method_model;

    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    logic        stall_request = 1'b0;
    int unsigned idle_run = 0;
    int unsigned beats_accepted = 0;
    int unsigned bytes_accepted = 0;
    int unsigned values_checked = 0;
    int unsigned mismatches = 0;
    int unsigned random_bytes = 0;
    logic [7:0]  methods_reported = 8'h00;

    multi_method_check_code_engine_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [7:0] data_byte
        .s_axis_tuser  (s_axis_tuser),   // [0] byte_present
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // [15:0] check_code
    );

    always #5 i_clk = ~i_clk;

    function automatic t_msg_sums fresh_sums();
        t_msg_sums s;
        s.crc     = cmce_pkg::CRC_INIT;
        s.parity  = 1'b0;
        s.csum    = 16'h0000;
        s.held_lo = 8'h00;
        s.odd     = 1'b0;
        s.lrc     = 8'h00;
        s.sig     = 16'h0000;
        s.bitpos  = cmce_pkg::BITPOS_INIT;
        return s;
    endfunction

    // 16-bit ones' complement add with the carry folded back in.
    function automatic logic [15:0] ones_sum16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[15:0] + {15'd0, t[16]};
    endfunction

    function automatic t_msg_sums fold_byte(input t_msg_sums s, input logic [7:0] b);
        t_msg_sums   n;
        logic [15:0] c;
        n = s;
        c = s.crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ cmce_pkg::CRC_POLY) : (c >> 1);
        end
        n.crc = c;
        for (int k = 0; k < 8; k++) begin
            if (b[k]) begin
                n.parity = ~n.parity;
                n.sig    = n.sig ^ n.bitpos;
            end
            n.bitpos = n.bitpos + 16'd1;
        end
        if (s.odd) begin
            n.csum    = ones_sum16(s.csum, {b, s.held_lo});
            n.odd     = 1'b0;
            n.held_lo = 8'h00;
        end else begin
            n.held_lo = b;
            n.odd     = 1'b1;
        end
        n.lrc = s.lrc ^ b;
        return n;
    endfunction

    function automatic logic [15:0] expected_code_of(input t_msg_sums s,
                                                     input logic [cmce_pkg::METHOD_W-1:0] m);
        logic [15:0] sum;
        case (m)
            cmce_pkg::METHOD_CRC16:  return s.crc;
            cmce_pkg::METHOD_PARITY: return {15'd0, s.parity};
            cmce_pkg::METHOD_INET: begin
                sum = s.csum;
                if (s.odd) begin
                    sum = ones_sum16(sum, {8'h00, s.held_lo});
                end
                return ~sum;
            end
            cmce_pkg::METHOD_LRC:    return {s.lrc, s.lrc ^ cmce_pkg::LRC_MASK};
            cmce_pkg::METHOD_BITSIG: return s.sig;
            default:                 return 16'h0000;
        endcase
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(7, 0))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Scoreboard: the output side is checked before the input side is folded in,
    // so a spurious result can never match an expectation pushed in the same cycle.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            method_model = cmce_pkg::METHOD_CRC16;
            sums = fresh_sums();
            expected_check_q.delete();
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_check_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: check value %04h arrived with none expected",
                             $time, m_axis_tdata);
                end else begin
                    values_checked++;
                    if (m_axis_tdata !== expected_check_q[0]) begin
                        mismatches++;
                        $display("%0t: check code mismatch, expected %04h, got %04h",
                                 $time, expected_check_q[0], m_axis_tdata);
                    end
                    void'(expected_check_q.pop_front());
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                beats_accepted++;
                if (s_axis_tuser) begin
                    sums = fold_byte(sums, s_axis_tdata);
                    bytes_accepted++;
                end
                if (s_axis_tlast) begin
                    expected_check_q.push_back(golden_valid ? golden_value
                                                            : expected_code_of(sums, method_model));
                    methods_reported[method_model] = 1'b1;
                    sums = fresh_sums();
                end
            end
            if (i_cfg_wr_en) begin
                method_model = i_cfg_wr_data;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_run = 0;
            end else begin
                idle_run++;
            end
            if (idle_run >= IDLE_LIMIT) begin
                $display("%0t: no beat moved for %0d cycles", $time, idle_run);
                $display("tb_multi_method_check_code_engine_core: FAIL");
                $finish;
            end
        end
    end

    // Result side: random back-pressure, or a long hold-off on request.
    initial begin
        forever begin
            @(posedge i_clk);
            if (stall_request) begin
                m_axis_tready <= 1'b0;
                repeat (STALL_CYCLES - 1) @(posedge i_clk);
                stall_request = 1'b0;
            end else begin
                m_axis_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
            end
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic present, input logic last,
                             input logic gv, input logic [15:0] g);
        while ($urandom_range(99, 0) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= present;
        s_axis_tlast  <= last;
        golden_valid  <= gv;
        golden_value  <= g;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Pause the byte stream until every outstanding check value has come back.
    task automatic settle_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_check_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic load_method(input logic [cmce_pkg::METHOD_W-1:0] m);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= m;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    // Mostly short messages, now and then a longer one; some ignored beats mixed in,
    // and some messages closed by a bare end beat instead of an end on the last byte.
    task automatic send_random_message();
        int unsigned len;
        logic        closed;
        logic        last;
        len = ($urandom_range(9, 0) == 0) ? $urandom_range(48, 9) : $urandom_range(8, 0);
        closed = 1'b0;
        for (int unsigned k = 0; k < len; k++) begin
            if ($urandom_range(19, 0) == 0) begin
                send_beat(8'($urandom), 1'b0, 1'b0, 1'b0, 16'h0000);
            end
            last = (k == len - 1) && ($urandom_range(3, 0) != 0);
            send_beat(pick_byte(), 1'b1, last, 1'b0, 16'h0000);
            random_bytes++;
            closed = last;
        end
        if (!closed) begin
            send_beat(8'($urandom), 1'b0, 1'b1, 1'b0, 16'h0000);
            random_bytes++;
        end
    endtask

    initial begin
        logic [cmce_pkg::METHOD_W-1:0] plan [6];
        int unsigned                   phase_start;
        int                            r;
        int                            mode;
        int                            p;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (r = 0; r < DIR_ROWS; r++) begin
            if (dir_tab[r].kind == ROW_CFG) begin
                settle_idle();
                load_method(dir_tab[r].method);
            end else begin
                send_beat(dir_tab[r].data_byte, dir_tab[r].byte_present,
                          dir_tab[r].end_of_message, dir_tab[r].golden_valid,
                          dir_tab[r].golden);
            end
        end
        settle_idle();

        plan[0] = cmce_pkg::METHOD_CRC16;
        plan[1] = cmce_pkg::METHOD_PARITY;
        plan[2] = cmce_pkg::METHOD_INET;
        plan[3] = cmce_pkg::METHOD_LRC;
        plan[4] = cmce_pkg::METHOD_BITSIG;
        for (mode = 0; mode < 3; mode++) begin
            case (mode)
                0: begin
                    send_idle_pct = 14;
                    recv_idle_pct = 77;
                    plan[5] = METHOD_RSVD_5;
                end
                1: begin
                    send_idle_pct = 77;
                    recv_idle_pct = 14;
                    plan[5] = METHOD_RSVD_6;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    plan[5] = METHOD_RSVD_7;
                end
            endcase
            for (p = 0; p < 6; p++) begin
                load_method(plan[(p + mode) % 6]);
                // With no random idling, hold the result side off long enough
                // for the block to fill and push back on the byte stream.
                if (mode == 2 && p == 0) begin
                    stall_request = 1'b1;
                end
                phase_start = random_bytes;
                while (random_bytes - phase_start < PHASE_BYTES) begin
                    send_random_message();
                end
                settle_idle();
            end
        end

        $display("Run covered %0d beats with %0d message bytes; %0d check values compared.",
                 beats_accepted, bytes_accepted, values_checked);
        $display("Method codes reported (one bit per code): %08b, under three idling mixes.",
                 methods_reported);
        if (mismatches == 0 && expected_check_q.size() == 0) begin
            $display("tb_multi_method_check_code_engine_core: PASS");
        end else begin
            $display("tb_multi_method_check_code_engine_core: FAIL");
        end
        $finish;
    end

endmodule

// File: multi_method_check_code_engine_core.f
hdl/cmce_pkg.sv
hdl/cmce_front.sv
hdl/cmce_queue.sv
hdl/cmce_back.sv
hdl/multi_method_check_code_engine_core.sv
tb/tb_multi_method_check_code_engine_core.sv
